// ===== rtl/core/pli_pkg.sv =====
// Package for the Phong light intensity block.
// Types, register codes, reset values and pipeline depths shared by all rtl/core files.
// No dependencies.
package pli_pkg;

  // pipeline geometry
  localparam int unsigned SPEC_EXP_DEF = 30;
  localparam int unsigned SQRT_STEPS   = 31;   // one root bit per stage
  localparam int unsigned DIV_STEPS    = 31;   // one quotient bit per stage
  // shift/abs, squares, sum, root, divide, sign restore
  localparam int unsigned NORM_LAT     = SQRT_STEPS + DIV_STEPS + 4;
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned CFG_AW       = 5;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_AMBIENT = 3'd0;
  localparam logic [2:0] REG_DIFFUSE = 3'd1;
  localparam logic [2:0] REG_LIGHT_X = 3'd2;
  localparam logic [2:0] REG_LIGHT_Y = 3'd3;
  localparam logic [2:0] REG_LIGHT_Z = 3'd4;
  localparam logic [2:0] REG_EYE_X   = 3'd5;
  localparam logic [2:0] REG_EYE_Y   = 3'd6;
  localparam logic [2:0] REG_EYE_Z   = 3'd7;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [16:0]        AMBIENT_RST = 17'd13107;
  localparam logic [16:0]        DIFFUSE_RST = 17'd32768;
  localparam logic signed [31:0] LIGHT_X_RST = 32'sd6553600;
  localparam logic signed [31:0] LIGHT_Y_RST = 32'sd6553600;
  localparam logic signed [31:0] LIGHT_Z_RST = -32'sd3276800;
  localparam logic signed [31:0] EYE_X_RST   = 32'sd0;
  localparam logic signed [31:0] EYE_Y_RST   = 32'sd0;
  localparam logic signed [31:0] EYE_Z_RST   = 32'sd0;

  typedef logic [2:0][32:0] vec33_t;   // raw vector, Q17.16, two's complement
  typedef logic [2:0][31:0] vec32_t;   // unit vector, Q2.30, two's complement

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic [16:0] intensity;
    logic        degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
  } scene_t;

  typedef struct packed {
    vec33_t n_vec;
    vec33_t e_vec;
    vec33_t l_vec;
    logic   degenerate;
  } q_item_t;

endpackage

// ===== rtl/core/pli_front.sv =====
// Front end: accepts items, forms normal, eye and light vectors, flags zero vectors.
// Uses pli_pkg; feeds pli_fifo.
module pli_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pli_pkg::in_item_t in_data,
  input  pli_pkg::scene_t   scene,
  output logic              q_push,
  output pli_pkg::q_item_t  q_item,
  input  logic              q_full
);

  logic              fr_valid_r, fr_valid_nxt;
  pli_pkg::q_item_t  fr_item_r, fr_item_nxt;
  logic              load;

  assign in_stall = fr_valid_r && q_full;
  assign q_push   = fr_valid_r && !q_full;
  assign load     = in_valid && !in_stall;
  assign q_item   = fr_item_r;

  always_comb begin
    fr_item_nxt.n_vec[0] = 33'(in_data.normal_x);
    fr_item_nxt.n_vec[1] = 33'(in_data.normal_y);
    fr_item_nxt.n_vec[2] = 33'(in_data.normal_z);
    fr_item_nxt.e_vec[0] = 33'(scene.eye_x) - 33'(in_data.point_x);
    fr_item_nxt.e_vec[1] = 33'(scene.eye_y) - 33'(in_data.point_y);
    fr_item_nxt.e_vec[2] = 33'(scene.eye_z) - 33'(in_data.point_z);
    fr_item_nxt.l_vec[0] = 33'(scene.light_x) - 33'(in_data.point_x);
    fr_item_nxt.l_vec[1] = 33'(scene.light_y) - 33'(in_data.point_y);
    fr_item_nxt.l_vec[2] = 33'(scene.light_z) - 33'(in_data.point_z);
    // any zero-length vector sends the item down the ambient-only path
    fr_item_nxt.degenerate = (fr_item_nxt.n_vec == '0) || (fr_item_nxt.e_vec == '0) ||
                             (fr_item_nxt.l_vec == '0);
    if (load) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

// ===== rtl/core/pli_fifo.sv =====
// Short queue between front and back end.
// Uses pli_pkg (Q_DEPTH, q_item_t).
module pli_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pli_pkg::q_item_t din,
  output logic             full,
  input  logic             pop,
  output pli_pkg::q_item_t dout,
  output logic             not_empty
);

  localparam int unsigned AW = $clog2(pli_pkg::Q_DEPTH);

  pli_pkg::q_item_t mem_r [pli_pkg::Q_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == (AW+1)'(pli_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/pli_norm.sv =====
// Vector normalizer: common shift, sum of squares, bit-serial pipelined root and divide.
// Uses pli_pkg (SQRT_STEPS, DIV_STEPS, vector types). Every stage advances only while en is high.
module pli_norm (
  input  logic            clk,
  input  logic            en,
  input  pli_pkg::vec33_t vec_i,
  output pli_pkg::vec32_t unit_o
);

  localparam int unsigned SQ = pli_pkg::SQRT_STEPS;
  localparam int unsigned DV = pli_pkg::DIV_STEPS;

  logic [2:0][32:0] mag;
  logic [32:0]      orv;
  logic [5:0]       msb;
  logic [2:0][29:0] sh;

  logic [2:0][29:0] a_sm_r, b_sm_r, c_sm_r;
  logic [2:0]       a_neg_r, b_neg_r, c_neg_r;
  logic [2:0][59:0] b_sq_r;
  logic [61:0]      c_sum_r;

  logic [61:0]      rt_rem_r  [SQ];
  logic [30:0]      rt_root_r [SQ];
  logic [2:0][29:0] rt_sm_r   [SQ];
  logic [2:0]       rt_neg_r  [SQ];

  logic [2:0][31:0] dv_rem_r  [DV];
  logic [2:0][30:0] dv_quo_r  [DV];
  logic [30:0]      dv_dsor_r [DV];
  logic [2:0]       dv_neg_r  [DV];

  pli_pkg::vec32_t  unit_r;

  assign unit_o = unit_r;

  // shift all magnitudes so that the largest lands in [2^29, 2^30)
  always_comb begin
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][32] ? (~vec_i[i] + 33'd1) : vec_i[i];
      orv    = orv | mag[i];
    end
    msb = '0;
    for (int b = 0; b < 33; b++) begin
      if (orv[b]) begin
        msb = 6'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (msb > 6'd29) begin
        sh[i] = 30'(mag[i] >> (msb - 6'd29));
      end else begin
        sh[i] = 30'(mag[i] << (6'd29 - msb));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sm_r  <= sh;
      for (int i = 0; i < 3; i++) begin
        a_neg_r[i] <= vec_i[i][32];
        b_sq_r[i]  <= 60'(a_sm_r[i]) * 60'(a_sm_r[i]);
      end
      b_sm_r  <= a_sm_r;
      b_neg_r <= a_neg_r;
      c_sum_r <= 62'(b_sq_r[0]) + 62'(b_sq_r[1]) + 62'(b_sq_r[2]);
      c_sm_r  <= b_sm_r;
      c_neg_r <= b_neg_r;
    end
  end

  // floor square root, one result bit per stage, MSB first
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    localparam int K = SQ - 1 - g;
    logic [63:0]      rem_in, trial;
    logic [30:0]      root_in;
    logic [2:0][29:0] sm_in;
    logic [2:0]       neg_in;
    if (g == 0) begin : g_first
      assign rem_in  = 64'(c_sum_r);
      assign root_in = '0;
      assign sm_in   = c_sm_r;
      assign neg_in  = c_neg_r;
    end else begin : g_next
      assign rem_in  = 64'(rt_rem_r[g-1]);
      assign root_in = rt_root_r[g-1];
      assign sm_in   = rt_sm_r[g-1];
      assign neg_in  = rt_neg_r[g-1];
    end
    assign trial = (64'(root_in) << (K + 1)) + (64'd1 << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rt_rem_r[g]  <= 62'(rem_in - trial);
          rt_root_r[g] <= root_in | (31'd1 << K);
        end else begin
          rt_rem_r[g]  <= 62'(rem_in);
          rt_root_r[g] <= root_in;
        end
        rt_sm_r[g]  <= sm_in;
        rt_neg_r[g] <= neg_in;
      end
    end
  end

  // restoring divide sm * 2^30 / root; remainder stays below twice the divisor
  for (genvar g = 0; g < DV; g++) begin : g_div
    logic [2:0][31:0] rem_in, rem_sub;
    logic [2:0][30:0] quo_in;
    logic [2:0]       qbit;
    logic [30:0]      dsor_in;
    logic [2:0]       neg_in;
    if (g == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = 32'(rt_sm_r[SQ-1][i]);
        end
      end
      assign quo_in  = '0;
      assign dsor_in = rt_root_r[SQ-1];
      assign neg_in  = rt_neg_r[SQ-1];
    end else begin : g_next
      assign rem_in  = dv_rem_r[g-1];
      assign quo_in  = dv_quo_r[g-1];
      assign dsor_in = dv_dsor_r[g-1];
      assign neg_in  = dv_neg_r[g-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        qbit[i] = (rem_in[i] >= 32'(dsor_in));
        rem_sub[i] = qbit[i] ? (rem_in[i] - 32'(dsor_in)) : rem_in[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[g][i] <= {rem_sub[i][30:0], 1'b0};
          dv_quo_r[g][i] <= {quo_in[i][29:0], qbit[i]};
        end
        dv_dsor_r[g] <= dsor_in;
        dv_neg_r[g]  <= neg_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        unit_r[i] <= dv_neg_r[DV-1][i] ? (32'd0 - 32'(dv_quo_r[DV-1][i]))
                                       : 32'(dv_quo_r[DV-1][i]);
      end
    end
  end

endmodule

// ===== rtl/core/pli_back.sv =====
// Back end: normalizes the three vectors, forms dot products, reflection, power and sum.
// Uses pli_pkg and pli_norm. Whole pipeline advances together unless the output stalls.
module pli_back #(
  parameter int unsigned SPEC_EXPONENT = pli_pkg::SPEC_EXP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pli_pkg::q_item_t   q_item,
  output logic               q_pop,
  input  logic [16:0]        ambient,
  input  logic [16:0]        diffuse,
  output logic               out_valid,
  input  logic               out_stall,
  output pli_pkg::out_item_t out_data
);

  localparam int unsigned BACK_LAT = pli_pkg::NORM_LAT + SPEC_EXPONENT + 8;
  localparam logic        ODD_EXP  = (SPEC_EXPONENT % 2) != 0;

  logic                  en;
  logic [BACK_LAT-1:0]   vld_r;
  logic [BACK_LAT-2:0]   deg_r;
  pli_pkg::vec32_t       un, ue, ul;

  logic signed [63:0]    s1_pnl_r [3];
  logic signed [63:0]    s1_pen_r [3];
  pli_pkg::vec32_t       s1_n_r, s1_e_r, s1_l_r;

  logic signed [65:0]    snl, sen, snl_q, snl_nq, sen_q;
  logic                  edn_neg, edn_pos, ldn_neg, ldn_pos;
  logic signed [33:0]    s2_ndl_r, s2_ndlu_r;
  logic                  s2_opp_r;
  pli_pkg::vec32_t       s2_n_r, s2_e_r, s2_l_r;

  logic signed [34:0]    nd2;
  logic signed [66:0]    s3_rp_r [3];
  logic [49:0]           s3_dp_r;
  logic                  s3_dpos_r, s3_opp_r;
  pli_pkg::vec32_t       s3_e_r, s3_l_r;

  logic signed [66:0]    rsh [3];
  logic signed [37:0]    s4_r_r [3];
  logic [19:0]           s4_diff_r;
  logic                  s4_opp_r;
  pli_pkg::vec32_t       s4_e_r;

  logic signed [69:0]    s5_rep_r [3];
  logic [19:0]           s5_diff_r;
  logic                  s5_opp_r;

  logic signed [71:0]    sre, rde;
  logic [71:0]           rmag;
  logic [30:0]           s6_a_r;
  logic                  s6_zp_r, s6_opp_r;
  logic [19:0]           s6_diff_r;

  logic [30:0]           pw_r   [SPEC_EXPONENT];
  logic [30:0]           pa_r   [SPEC_EXPONENT];
  logic                  pzp_r  [SPEC_EXPONENT];
  logic                  popp_r [SPEC_EXPONENT];
  logic [19:0]           pdif_r [SPEC_EXPONENT];

  logic signed [18:0]    sw_full;
  logic [16:0]           sw;
  logic [47:0]           f1_sp_r;
  logic                  f1_zp_r, f1_opp_r;
  logic [19:0]           f1_diff_r;

  logic [17:0]           spec;
  logic [19:0]           diff_use;
  logic [19:0]           total;
  pli_pkg::out_item_t    out_nxt, out_r;

  assign out_valid = vld_r[BACK_LAT-1];
  assign en        = !out_valid || !out_stall;
  assign q_pop     = en && q_valid;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BACK_LAT-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= {deg_r[BACK_LAT-3:0], q_item.degenerate};
    end
  end

  pli_norm u_norm_n (.clk(clk), .en(en), .vec_i(q_item.n_vec), .unit_o(un));
  pli_norm u_norm_e (.clk(clk), .en(en), .vec_i(q_item.e_vec), .unit_o(ue));
  pli_norm u_norm_l (.clk(clk), .en(en), .vec_i(q_item.l_vec), .unit_o(ul));

  // dot products: floor of the exact sum over 2^30; flipped N.L is floored separately
  always_comb begin
    snl    = 66'(s1_pnl_r[0]) + 66'(s1_pnl_r[1]) + 66'(s1_pnl_r[2]);
    sen    = 66'(s1_pen_r[0]) + 66'(s1_pen_r[1]) + 66'(s1_pen_r[2]);
    snl_q  = snl >>> 30;
    snl_nq = (-snl) >>> 30;
    sen_q  = sen >>> 30;
    edn_neg = sen_q < 0;
    edn_pos = sen_q > 0;
    ldn_neg = snl_q < 0;
    ldn_pos = snl_q > 0;
    nd2     = {s2_ndl_r, 1'b0};
    for (int i = 0; i < 3; i++) begin
      rsh[i] = s3_rp_r[i] >>> 30;
    end
    sre  = 72'(s5_rep_r[0]) + 72'(s5_rep_r[1]) + 72'(s5_rep_r[2]);
    rde  = sre >>> 30;
    rmag = rde[71] ? 72'(-rde) : 72'(rde);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_pnl_r[i] <= $signed(un[i]) * $signed(ul[i]);
        s1_pen_r[i] <= $signed(ue[i]) * $signed(un[i]);
      end
      s1_n_r <= un;
      s1_e_r <= ue;
      s1_l_r <= ul;

      s2_ndl_r  <= snl_q[33:0];
      // both eye and light behind the surface: shade the flipped normal
      s2_ndlu_r <= (edn_neg && ldn_neg) ? snl_nq[33:0] : snl_q[33:0];
      s2_opp_r  <= (edn_neg && ldn_pos) || (edn_pos && ldn_neg);
      s2_n_r    <= s1_n_r;
      s2_e_r    <= s1_e_r;
      s2_l_r    <= s1_l_r;

      for (int i = 0; i < 3; i++) begin
        s3_rp_r[i] <= nd2 * $signed(s2_n_r[i]);
      end
      s3_dp_r   <= 50'(diffuse) * 50'(s2_ndlu_r[32:0]);
      s3_dpos_r <= s2_ndlu_r > 0;
      s3_opp_r  <= s2_opp_r;
      s3_e_r    <= s2_e_r;
      s3_l_r    <= s2_l_r;

      for (int i = 0; i < 3; i++) begin
        s4_r_r[i] <= rsh[i][37:0] - 38'($signed(s3_l_r[i]));
      end
      s4_diff_r <= s3_dpos_r ? 20'(s3_dp_r >> 30) : '0;
      s4_opp_r  <= s3_opp_r;
      s4_e_r    <= s3_e_r;

      for (int i = 0; i < 3; i++) begin
        s5_rep_r[i] <= s4_r_r[i] * $signed(s4_e_r[i]);
      end
      s5_diff_r <= s4_diff_r;
      s5_opp_r  <= s4_opp_r;

      s6_a_r    <= (rmag > (72'd1 << 30)) ? (31'd1 << 30) : rmag[30:0];
      s6_zp_r   <= rde[71] && ODD_EXP;
      s6_opp_r  <= s5_opp_r;
      s6_diff_r <= s5_diff_r;
    end
  end

  // power chain: one multiply per stage, starting from 1.0
  for (genvar g = 0; g < SPEC_EXPONENT; g++) begin : g_pow
    logic [30:0] p_in, a_in;
    logic        zp_in, opp_in;
    logic [19:0] dif_in;
    logic [61:0] prod;
    if (g == 0) begin : g_first
      assign p_in   = 31'd1 << 30;
      assign a_in   = s6_a_r;
      assign zp_in  = s6_zp_r;
      assign opp_in = s6_opp_r;
      assign dif_in = s6_diff_r;
    end else begin : g_next
      assign p_in   = pw_r[g-1];
      assign a_in   = pa_r[g-1];
      assign zp_in  = pzp_r[g-1];
      assign opp_in = popp_r[g-1];
      assign dif_in = pdif_r[g-1];
    end
    assign prod = 62'(p_in) * 62'(a_in);
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[g]   <= 31'(prod >> 30);
        pa_r[g]   <= a_in;
        pzp_r[g]  <= zp_in;
        popp_r[g] <= opp_in;
        pdif_r[g] <= dif_in;
      end
    end
  end

  always_comb begin
    sw_full  = 19'sd65536 - $signed(19'(ambient)) - $signed(19'(diffuse));
    sw       = sw_full[18] ? '0 : sw_full[16:0];
    spec     = (f1_zp_r || f1_opp_r) ? '0 : 18'(f1_sp_r >> 30);
    diff_use = f1_opp_r ? '0 : f1_diff_r;
    total    = 20'(ambient) + diff_use + 20'(spec);
    if (deg_r[BACK_LAT-2]) begin
      out_nxt.intensity  = (ambient > pli_pkg::ONE_Q16) ? pli_pkg::ONE_Q16 : ambient;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.intensity  = (total > 20'(pli_pkg::ONE_Q16)) ? pli_pkg::ONE_Q16 : total[16:0];
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sp_r   <= 48'(sw) * 48'(pw_r[SPEC_EXPONENT-1]);
      f1_zp_r   <= pzp_r[SPEC_EXPONENT-1];
      f1_opp_r  <= popp_r[SPEC_EXPONENT-1];
      f1_diff_r <= pdif_r[SPEC_EXPONENT-1];
      out_r     <= out_nxt;
    end
  end

endmodule

// ===== rtl/core/phong_light_intensity.sv =====
// Top level of the Phong light intensity block: register file, front end, queue, back end.
// Uses pli_pkg, pli_front, pli_fifo and pli_back.
//
// One shaded result comes out per surface point, and a new point is taken every
// clock while in_stall is low: the work is one long pipeline with no loop back.
// The pipeline's length is set by the bit-serial square root and divide in each
// of the three vector normalizers (31 stages each) plus one multiplier stage per
// power of the specular term. The front end registers the eye and light vectors
// and flags zero-length vectors; a four-item queue sits between it and the back
// end, so input stalls only when that queue and the front register are both
// full. The back pipeline freezes as a whole while a finished item waits on
// out_stall. Registers are written over the APB port only while no item is in
// flight: the user must keep to this, as the block itself does not enforce it.
module phong_light_intensity #(
  parameter int unsigned SPEC_EXPONENT = pli_pkg::SPEC_EXP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pli_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pli_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pli_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [16:0]      ambient_r, diffuse_r;
  pli_pkg::scene_t  scene_r;
  logic             cfg_wr;
  logic [2:0]       reg_idx;

  logic             q_push, q_full, q_pop, q_valid;
  pli_pkg::q_item_t q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ambient_r       <= pli_pkg::AMBIENT_RST;
      diffuse_r       <= pli_pkg::DIFFUSE_RST;
      scene_r.light_x <= pli_pkg::LIGHT_X_RST;
      scene_r.light_y <= pli_pkg::LIGHT_Y_RST;
      scene_r.light_z <= pli_pkg::LIGHT_Z_RST;
      scene_r.eye_x   <= pli_pkg::EYE_X_RST;
      scene_r.eye_y   <= pli_pkg::EYE_Y_RST;
      scene_r.eye_z   <= pli_pkg::EYE_Z_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        pli_pkg::REG_AMBIENT: ambient_r       <= pwdata[16:0];
        pli_pkg::REG_DIFFUSE: diffuse_r       <= pwdata[16:0];
        pli_pkg::REG_LIGHT_X: scene_r.light_x <= pwdata;
        pli_pkg::REG_LIGHT_Y: scene_r.light_y <= pwdata;
        pli_pkg::REG_LIGHT_Z: scene_r.light_z <= pwdata;
        pli_pkg::REG_EYE_X:   scene_r.eye_x   <= pwdata;
        pli_pkg::REG_EYE_Y:   scene_r.eye_y   <= pwdata;
        pli_pkg::REG_EYE_Z:   scene_r.eye_z   <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      pli_pkg::REG_AMBIENT: prdata = 32'(ambient_r);
      pli_pkg::REG_DIFFUSE: prdata = 32'(diffuse_r);
      pli_pkg::REG_LIGHT_X: prdata = scene_r.light_x;
      pli_pkg::REG_LIGHT_Y: prdata = scene_r.light_y;
      pli_pkg::REG_LIGHT_Z: prdata = scene_r.light_z;
      pli_pkg::REG_EYE_X:   prdata = scene_r.eye_x;
      pli_pkg::REG_EYE_Y:   prdata = scene_r.eye_y;
      pli_pkg::REG_EYE_Z:   prdata = scene_r.eye_z;
      default:              prdata = '0;
    endcase
  end

  pli_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .scene    (scene_r),
    .q_push   (q_push),
    .q_item   (q_in),
    .q_full   (q_full)
  );

  pli_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_out),
    .not_empty (q_valid)
  );

  pli_back #(
    .SPEC_EXPONENT (SPEC_EXPONENT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .ambient   (ambient_r),
    .diffuse   (diffuse_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/pli_checker.sv =====
// Port-level checks for phong_light_intensity, attached by bind.
// Uses pli_pkg types; sees the top-level ports only.
module pli_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pli_pkg::out_item_t out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // intensity saturates at 1.0
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.intensity <= pli_pkg::ONE_Q16)
    else $error("intensity above 1.0");

  // pipeline is empty right after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("result or stall right after reset");

  // input can only stall once something has been taken in
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid) || $past(in_stall))
    else $error("stall with no item taken");

endmodule

bind phong_light_intensity pli_checker u_pli_checker (.*);
